FILE: design/assert_macros.svh
// assertion macros used by the top-level design file
// no dependencies; define SYNTH to drop all checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: ante |-> cons");
// antecedent implies consequent in the next cycle
`define ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");
`else
`define ASSERT_IMP(name, clk, rst_n, ante, cons)
`define ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/skf_pkg.sv
// shared types and constants of the scalar kalman filter
// no dependencies
package skf_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned GAIN_W    = 17;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CNT_W     = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ESTIMATE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VARIANCE  = 8'd3;

    // reset values
    localparam logic [DATA_W-1:0] RST_PROCESS_NOISE     = 32'd65;
    localparam logic [DATA_W-1:0] RST_MEASUREMENT_NOISE = 32'd65536;
    localparam logic [DATA_W-1:0] RST_INITIAL_ESTIMATE  = 32'd0;
    localparam logic [DATA_W-1:0] RST_INITIAL_VARIANCE  = 32'd65536;

    // unity gain in q1.16
    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_MULX,
        S_UPDX,
        S_UPDV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic setup;
        logic div_step;
        logic mul_x;
        logic upd_x;
        logic upd_v;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;

endpackage

FILE: design/skf_ctrl.sv
// sequencer of the scalar kalman filter: one word at a time
// depends on skf_pkg
module skf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  skf_pkg::t_status i_status,
    output skf_pkg::t_cmd    o_cmd
);
    import skf_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_SETUP;
            S_SETUP: n_state = S_DIV;
            S_DIV:   if (i_status.div_done) n_state = S_MULX;
            S_MULX:  n_state = S_UPDX;
            S_UPDX:  n_state = S_UPDV;
            S_UPDV:  n_state = S_OUT;
            S_OUT:   if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd          = '0;
        o_in_stall     = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            S_SETUP: o_cmd.setup    = 1'b1;
            S_DIV:   o_cmd.div_step = 1'b1;
            S_MULX:  o_cmd.mul_x    = 1'b1;
            S_UPDX:  o_cmd.upd_x    = 1'b1;
            S_UPDV:  o_cmd.upd_v    = 1'b1;
            S_OUT:   o_cmd.out_load = !r_out_valid || !i_out_stall;
            default: o_cmd          = '0;
        endcase
    end

    // output word holding register flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: design/skf_dp.sv
// datapath of the scalar kalman filter: state, registers, divider, multiplier
// depends on skf_pkg
module skf_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  skf_pkg::t_cmd                       i_cmd,
    output skf_pkg::t_status                    o_status,
    input  logic                                i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]          i_cfg_data,
    input  logic signed [skf_pkg::SAMPLE_W-1:0] i_sample,
    output logic signed [skf_pkg::DATA_W-1:0]   o_estimate,
    output logic [skf_pkg::GAIN_W-1:0]          o_gain
);
    import skf_pkg::*;

    logic [DATA_W-1:0]          r_pn, r_mn, r_est, r_var;
    logic [DATA_W-1:0]          r_pred;
    logic [SAMPLE_W-1:0]        r_sample;
    logic [DATA_W:0]            r_sum;
    logic                       r_sum_zero;
    logic [DATA_W+1:0]          r_rem;
    logic [GAIN_W-1:0]          r_quo;
    logic [CNT_W-1:0]           r_cnt;
    logic [DATA_W:0]            r_diff;
    logic signed [GAIN_W+DATA_W+1:0] r_prod;
    logic [DATA_W-1:0]          r_out_est;
    logic [GAIN_W-1:0]          r_out_gain;

    logic [DATA_W:0]            w_pred_full;
    logic [DATA_W+1:0]          w_trial;
    logic                       w_ge;
    logic [GAIN_W-1:0]          w_gain;
    logic signed [GAIN_W:0]     w_mul_a;
    logic signed [DATA_W+1:0]   w_mul_b;
    logic signed [GAIN_W+DATA_W+1:0] w_prod;
    logic [DATA_W+4:0]          w_nx;
    logic                       w_fits;
    logic [DATA_W-1:0]          w_est_next;

    // predicted variance, saturating
    assign w_pred_full = {1'b0, r_var} + {1'b0, r_pn};

    // one restoring division step per cycle; first step has no shift
    assign w_trial = (r_cnt == CNT_W'(GAIN_W - 1)) ? r_rem : {r_rem[DATA_W:0], 1'b0};
    assign w_ge    = w_trial >= {1'b0, r_sum};
    assign o_status.div_done = (r_cnt == '0);

    // gain is zero when the denominator is zero
    assign w_gain = r_sum_zero ? '0 : r_quo;

    // shared multiplier: gain * diff, then (1 - gain) * pred
    assign w_mul_a = i_cmd.upd_x ? {1'b0, GAIN_ONE - w_gain} : {1'b0, w_gain};
    assign w_mul_b = i_cmd.upd_x ? {2'b00, r_pred} : {r_diff[DATA_W], r_diff};
    assign w_prod  = w_mul_a * w_mul_b;

    // estimate plus floored step, clamped to 32 bits signed
    assign w_nx   = {{2{r_prod[GAIN_W+DATA_W+1]}}, r_prod[GAIN_W+DATA_W+1:FRAC_W]}
                  + {{5{r_est[DATA_W-1]}}, r_est};
    assign w_fits = (w_nx[DATA_W+4:DATA_W-1] == '0) || (w_nx[DATA_W+4:DATA_W-1] == '1);
    always_comb begin
        if (w_fits) begin
            w_est_next = w_nx[DATA_W-1:0];
        end else if (w_nx[DATA_W+4]) begin
            w_est_next = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            w_est_next = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    // configuration and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pn  <= RST_PROCESS_NOISE;
            r_mn  <= RST_MEASUREMENT_NOISE;
            r_est <= RST_INITIAL_ESTIMATE;
            r_var <= RST_INITIAL_VARIANCE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PROCESS_NOISE:     r_pn  <= i_cfg_data;
                    REG_MEASUREMENT_NOISE: r_mn  <= i_cfg_data;
                    REG_INITIAL_ESTIMATE:  r_est <= i_cfg_data;
                    REG_INITIAL_VARIANCE:  r_var <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.upd_x) r_est <= w_est_next;
            if (i_cmd.upd_v) r_var <= r_prod[DATA_W+FRAC_W-1:FRAC_W];
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
            r_pred   <= w_pred_full[DATA_W] ? '1 : w_pred_full[DATA_W-1:0];
        end
        if (i_cmd.setup) begin
            r_sum      <= {1'b0, r_pred} + {1'b0, r_mn};
            r_sum_zero <= (r_pred == '0) && (r_mn == '0);
            r_rem      <= {2'b00, r_pred};
            r_quo      <= '0;
            r_cnt      <= CNT_W'(GAIN_W - 1);
            r_diff     <= {r_sample[SAMPLE_W-1], r_sample, {FRAC_W{1'b0}}}
                        - {r_est[DATA_W-1], r_est};
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? (w_trial - {1'b0, r_sum}) : w_trial;
            r_quo <= {r_quo[GAIN_W-2:0], w_ge};
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.mul_x || i_cmd.upd_x) begin
            r_prod <= w_prod;
        end
        if (i_cmd.out_load) begin
            r_out_est  <= r_est;
            r_out_gain <= w_gain;
        end
    end

    assign o_estimate = r_out_est;
    assign o_gain     = r_out_gain;

endmodule

FILE: design/scalar_kalman_filter.sv
// scalar kalman filter top level: one sample word in, one estimate/gain word out
// the gain comes from a radix-2 restoring divider, run between setup and the multiplies
// the next sample is taken once the last result is loaded, also while that result waits
// reset (synchronous, active low) loads the default noise and initial state values
// depends on skf_pkg, skf_ctrl, skf_dp and assert_macros.svh
`include "assert_macros.svh"

module scalar_kalman_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [skf_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [skf_pkg::DATA_W-1:0]   o_estimate,
    output logic [skf_pkg::GAIN_W-1:0]          o_gain,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [skf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]          i_cfg_data
);
    import skf_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    skf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    skf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_sample),
        .o_estimate  (o_estimate),
        .o_gain      (o_gain)
    );

    // checks
    `ASSERT_IMP(a_gain_range, i_clk, i_rst_n, o_valid, o_gain <= GAIN_ONE)
    `ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_cmd.accept, o_stall)
    `ASSERT_NXT(a_load_gives_valid, i_clk, i_rst_n, w_cmd.out_load, o_valid)
    `ASSERT_IMP(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0(w_cmd))

endmodule
